FILE: src/lpfr_pkg.sv
// Shared types and constants for the LRU page frame replacer.
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

    // Frame set geometry.
    localparam int FRAMES  = 8;
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W  = FRAME_W;
    localparam int PAGE_W  = 8;
    localparam int CFG_W   = 4;
    localparam int FAULT_W = 16;

    localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(FRAMES - 1);
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    // Result codes.
    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef logic [FRAMES-1:0][PAGE_W-1:0] t_page_vec;
    typedef logic [FRAMES-1:0][RANK_W-1:0] t_rank_vec;

    // Lookup result for one reference.
    typedef struct packed {
        t_outcome           outcome;
        logic [FRAME_W-1:0] frame;
        logic [FRAMES-1:0]  active;
    } t_decision;

    // Update request to the frame table.
    typedef struct packed {
        logic               en;
        logic               fill;
        logic [FRAMES-1:0]  active;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  page;
    } t_update;

endpackage

`default_nettype wire

FILE: src/lru_page_frame_replacer_core.sv
// Top level of the LRU page frame replacer.
// A word passes the input register and then the result register before its result strobe.
// Throughput: one word per cycle; the lookup is combinational and the rank update is written with the result.
// busy is always low and results are never held off, so the receiver cannot stall.
// Reset (synchronous, active low) clears all frames, ranks and the fault count,
// and sets the frame limit to eight; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_frame_replacer_core
    import lpfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [PAGE_W-1:0]  i_page,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    output logic                    o_valid,
    output logic [1:0]              o_outcome,
    output logic [FRAME_W-1:0]      o_frame,
    output logic [PAGE_W-1:0]       o_evicted_page,
    output logic [FAULT_W-1:0]      o_fault_total
);

    logic               r_in_valid;
    logic [PAGE_W-1:0]  r_in_page;
    logic [CFG_W-1:0]   r_limit;
    logic [FAULT_W-1:0] r_fault;
    logic [FAULT_W-1:0] n_fault;
    logic               r_out_valid;
    t_outcome           r_outcome;
    logic [FRAME_W-1:0] r_frame;
    logic [PAGE_W-1:0]  r_evicted;
    logic [PAGE_W-1:0]  n_evicted;

    logic [FRAMES-1:0]  tbl_valid;
    t_page_vec          tbl_pages;
    t_rank_vec          tbl_ranks;
    t_decision          decision;
    t_update            upd;

    // A word is taken whenever start is high.
    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in_page <= i_page;
        end
    end

    // Frame limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    lpfr_lookup u_lookup (
        .i_limit    (r_limit),
        .i_page     (r_in_page),
        .i_valid    (tbl_valid),
        .i_pages    (tbl_pages),
        .i_ranks    (tbl_ranks),
        .o_decision (decision)
    );

    // Update request for the frame table.
    always_comb begin
        upd.en     = r_in_valid;
        upd.fill   = (decision.outcome == OUT_FILL);
        upd.active = decision.active;
        upd.frame  = decision.frame;
        upd.page   = r_in_page;
    end

    lpfr_frame_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_valid (tbl_valid),
        .o_pages (tbl_pages),
        .o_ranks (tbl_ranks)
    );

    // Saturating fault count and the evicted page.
    always_comb begin
        n_fault = r_fault;
        if (r_in_valid && (decision.outcome != OUT_HIT) && (r_fault != FAULT_MAX)) begin
            n_fault = r_fault + 1'b1;
        end
        if (decision.outcome == OUT_EVICT) begin
            n_evicted = tbl_pages[decision.frame];
        end else begin
            n_evicted = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fault     <= n_fault;
            r_out_valid <= r_in_valid;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_outcome <= decision.outcome;
            r_frame   <= decision.frame;
            r_evicted <= n_evicted;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_frame        = r_frame;
    assign o_evicted_page = r_evicted;
    assign o_fault_total  = r_fault;

    // Every accepted word yields a result after the input and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted word produced no result");

    // A hit leaves the fault count alone.
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome == OUT_HIT)) |-> (o_fault_total == $past(o_fault_total)))
        else $error("fault count moved on a hit");

    // A fault below saturation bumps the count by one.
    a_fault_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome != OUT_HIT) && ($past(o_fault_total) != FAULT_MAX))
            |-> (o_fault_total == FAULT_W'($past(o_fault_total) + 1'b1)))
        else $error("fault count not incremented");

    // Only a replacement reports an evicted page.
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome != OUT_EVICT)) |-> (o_evicted_page == '0))
        else $error("evicted page reported without replacement");

endmodule

`default_nettype wire

FILE: src/lpfr_lookup.sv
// Parallel tag match, empty-frame search and LRU victim selection.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_lookup
    import lpfr_pkg::*;
(
    input  wire logic [CFG_W-1:0]  i_limit,
    input  wire logic [PAGE_W-1:0] i_page,
    input  wire logic [FRAMES-1:0] i_valid,
    input  wire t_page_vec         i_pages,
    input  wire t_rank_vec         i_ranks,
    output t_decision              o_decision
);

    logic [CFG_W-1:0]   limit_eff;
    logic [FRAMES-1:0]  active;
    logic               hit_found;
    logic [FRAME_W-1:0] hit_idx;
    logic               empty_found;
    logic [FRAME_W-1:0] empty_idx;
    logic               vic_found;
    logic [FRAME_W-1:0] vic_idx;
    logic [RANK_W-1:0]  vic_rank;

    // Clamp the frame limit to the range one to FRAMES.
    always_comb begin
        if (i_limit == '0) begin
            limit_eff = CFG_W'(1);
        end else if (i_limit > CFG_W'(FRAMES)) begin
            limit_eff = CFG_W'(FRAMES);
        end else begin
            limit_eff = i_limit;
        end
    end

    // Scan the frames in use: lowest match, lowest empty, lowest oldest.
    always_comb begin
        active      = '0;
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        vic_found   = 1'b0;
        vic_idx     = '0;
        vic_rank    = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (CFG_W'(i) < limit_eff) begin
                active[i] = 1'b1;
                if (i_valid[i]) begin
                    if (!hit_found && (i_pages[i] == i_page)) begin
                        hit_found = 1'b1;
                        hit_idx   = FRAME_W'(i);
                    end
                    if (!vic_found || (i_ranks[i] > vic_rank)) begin
                        vic_found = 1'b1;
                        vic_idx   = FRAME_W'(i);
                        vic_rank  = i_ranks[i];
                    end
                end else if (!empty_found) begin
                    empty_found = 1'b1;
                    empty_idx   = FRAME_W'(i);
                end
            end
        end
    end

    // Pick the outcome: hit first, then fill, else replace the victim.
    always_comb begin
        o_decision.active = active;
        if (hit_found) begin
            o_decision.outcome = OUT_HIT;
            o_decision.frame   = hit_idx;
        end else if (empty_found) begin
            o_decision.outcome = OUT_FILL;
            o_decision.frame   = empty_idx;
        end else begin
            o_decision.outcome = OUT_EVICT;
            o_decision.frame   = vic_idx;
        end
    end

endmodule

`default_nettype wire

FILE: src/lpfr_frame_table.sv
// Frame table: valid bits, resident pages and recency ranks.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_frame_table
    import lpfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_update     i_upd,
    output logic [FRAMES-1:0] o_valid,
    output t_page_vec        o_pages,
    output t_rank_vec        o_ranks
);

    logic [FRAMES-1:0] r_valid;
    logic [FRAMES-1:0] n_valid;
    t_rank_vec         r_rank;
    t_rank_vec         n_rank;
    t_page_vec         r_page;
    logic [RANK_W-1:0] bound;

    // Rank of the chosen frame; younger frames age past it.
    assign bound = r_rank[i_upd.frame];

    // Next ranks and valid bits.
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_upd.en) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (i_upd.active[i] && r_valid[i]
                        && (i_upd.fill || (r_rank[i] < bound))
                        && (r_rank[i] != RANK_MAX)) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
            n_rank[i_upd.frame]  = '0;
            n_valid[i_upd.frame] = 1'b1;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    // Resident pages; read only behind a set valid bit.
    always_ff @(posedge i_clk) begin
        if (i_upd.en) begin
            r_page[i_upd.frame] <= i_upd.page;
        end
    end

    assign o_valid = r_valid;
    assign o_pages = r_page;
    assign o_ranks = r_rank;

    // The frame just used is valid and most recent.
    a_used_is_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_upd.en))
            |-> (r_valid[$past(i_upd.frame)] && (r_rank[$past(i_upd.frame)] == '0)))
        else $error("used frame not marked most recent");

    // Frame zero, while invalid and not chosen, keeps rank zero.
    a_invalid_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_valid[0]) |-> (r_rank[0] == '0))
        else $error("invalid frame carries a nonzero rank");

endmodule

`default_nettype wire
